>>> design/fnv64cd_pkg.sv
// Package for the chained FNV-64 digest block: types, constants and the FNV byte step.
// It has no dependencies. The controller, datapath and top level import it.
`timescale 1ns / 1ps

package fnv64cd_pkg;

  localparam logic [63:0] FNV_BASIS = 64'hCBF2_9CE4_8422_2325;

  typedef enum logic [2:0] {
    ST_STREAM,
    ST_A1,
    ST_E1,
    ST_H2,
    ST_A2,
    ST_E2
  } fsm_state_t;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_STEP,
    OP_SEAL,
    OP_MIX,
    OP_EMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   use_in_byte;
    logic   fnv1a;
  } dp_cmd_t;

  // Multiply by the prime 2^40 + 0x1b3, modulo 2^64, as a sum of shifted copies.
  function automatic logic [63:0] fnv_mul(input logic [63:0] x);
    fnv_mul = (x << 40) + x + (x << 1) + (x << 4) + (x << 5) + (x << 7) + (x << 8);
  endfunction

  function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [7:0] b,
                                           input logic alt);
    logic [63:0] ext_b;
    ext_b = {56'd0, b};
    if (alt) begin
      fnv_step = fnv_mul(h ^ ext_b);
    end else begin
      fnv_step = fnv_mul(h) ^ ext_b;
    end
  endfunction

  function automatic logic [63:0] bswap64(input logic [63:0] v);
    for (int i = 0; i < 8; i++) begin
      bswap64[8*i +: 8] = v[8*(7-i) +: 8];
    end
  endfunction

endpackage

>>> design/fnv64_chained_digest.sv
// Top level of the chained FNV-64 digest: joins fnv64cd_ctrl and fnv64cd_datapath.
// It depends on fnv64cd_pkg and both submodules.
//
//   channel  direction  ports
//   in       input      in_valid, in_ready, in_byte, in_last_byte
//   out      output     out_valid, out_ready, out_digest_word, out_final_word
//
// Message bytes are absorbed one per cycle while the input is ready, one FNV-1 step per byte.
// The last byte starts a finish of 40 byte steps on the shared FNV step unit,
// and the input is not ready again until that finish is done.
// The first digest word appears after 16 finishing steps and the second after 40.
// A stalled output holds the finish before each emit until the output register frees.
// Reset is synchronous and active low; it returns the hash to the offset basis.
`timescale 1ns / 1ps

module fnv64_chained_digest import fnv64cd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_digest_word,
  output logic        out_final_word
);

  dp_cmd_t cmd;

  fnv64cd_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_last_byte   (in_last_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_final_word (out_final_word),
    .cmd            (cmd)
  );

  fnv64cd_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_byte         (in_byte),
    .out_digest_word (out_digest_word)
  );

endmodule

>>> design/fnv64cd_datapath.sv
// Datapath for the chained FNV-64 digest: hash accumulator, source word, saved hash and output word.
// It depends on fnv64cd_pkg and is driven by commands from fnv64cd_ctrl.
`timescale 1ns / 1ps

module fnv64cd_datapath import fnv64cd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  dp_cmd_t     cmd,
  input  logic [7:0]  in_byte,
  output logic [63:0] out_digest_word
);

  logic [63:0] acc_r, acc_nxt;
  logic [63:0] src_r, src_nxt;
  logic [63:0] hsave_r, hsave_nxt;
  logic [63:0] word_r, word_nxt;
  logic [7:0]  step_byte;
  logic [63:0] step_res;

  assign step_byte = cmd.use_in_byte ? in_byte : src_r[63:56];
  assign step_res  = fnv_step(acc_r, step_byte, cmd.fnv1a);

  always_comb begin
    acc_nxt   = acc_r;
    src_nxt   = src_r;
    hsave_nxt = hsave_r;
    word_nxt  = word_r;
    unique case (cmd.op)
      OP_HOLD: begin
      end
      OP_STEP: begin
        acc_nxt = step_res;
        src_nxt = {src_r[55:0], 8'd0};
      end
      OP_SEAL: begin
        hsave_nxt = step_res;
        src_nxt   = step_res;
        acc_nxt   = FNV_BASIS;
      end
      OP_MIX: begin
        src_nxt = hsave_r ^ bswap64(step_res);
        acc_nxt = FNV_BASIS;
      end
      OP_EMIT: begin
        word_nxt = step_res;
        src_nxt  = step_res;
        acc_nxt  = FNV_BASIS;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= FNV_BASIS;
    end else begin
      acc_r <= acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    src_r   <= src_nxt;
    hsave_r <= hsave_nxt;
    word_r  <= word_nxt;
  end

  assign out_digest_word = word_r;

endmodule

>>> design/fnv64cd_ctrl.sv
// Controller for the chained FNV-64 digest: steps the streamed bytes and sequences the 40 finishing byte steps.
// It depends on fnv64cd_pkg and issues commands to fnv64cd_datapath.
`timescale 1ns / 1ps

module fnv64cd_ctrl import fnv64cd_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  logic    in_last_byte,
  output logic    out_valid,
  input  logic    out_ready,
  output logic    out_final_word,
  output dp_cmd_t cmd
);

  fsm_state_t state_r, state_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       final_r, final_nxt;
  logic       out_free;
  logic       last_step;
  logic       in_fire;

  assign out_free  = !out_valid_r || out_ready;
  assign last_step = (cnt_r == 3'd7);
  assign in_ready  = (state_r == ST_STREAM);
  assign in_fire   = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_STREAM: if (in_fire && in_last_byte) state_nxt = ST_A1;
      ST_A1:     if (last_step) state_nxt = ST_E1;
      ST_E1:     if (last_step && out_free) state_nxt = ST_H2;
      ST_H2:     if (last_step) state_nxt = ST_A2;
      ST_A2:     if (last_step) state_nxt = ST_E2;
      ST_E2:     if (last_step && out_free) state_nxt = ST_STREAM;
      default:   state_nxt = ST_STREAM;
    endcase
  end

  always_comb begin
    cmd.op          = OP_HOLD;
    cmd.use_in_byte = 1'b0;
    cmd.fnv1a       = 1'b1;
    cnt_nxt         = cnt_r;
    final_nxt       = final_r;
    out_valid_nxt   = out_ready ? 1'b0 : out_valid_r;
    unique case (state_r)
      ST_STREAM: begin
        cmd.use_in_byte = 1'b1;
        cmd.fnv1a       = 1'b0;
        cnt_nxt         = 3'd0;
        if (in_fire) begin
          cmd.op = in_last_byte ? OP_SEAL : OP_STEP;
        end
      end
      ST_A1, ST_A2: begin
        cmd.op  = last_step ? OP_MIX : OP_STEP;
        cnt_nxt = cnt_r + 3'd1;
      end
      ST_H2: begin
        cmd.fnv1a = 1'b0;
        cmd.op    = last_step ? OP_SEAL : OP_STEP;
        cnt_nxt   = cnt_r + 3'd1;
      end
      ST_E1, ST_E2: begin
        if (!last_step) begin
          cmd.op  = OP_STEP;
          cnt_nxt = cnt_r + 3'd1;
        end else if (out_free) begin
          cmd.op        = OP_EMIT;
          cnt_nxt       = 3'd0;
          out_valid_nxt = 1'b1;
          final_nxt     = (state_r == ST_E2);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_STREAM;
      cnt_r       <= 3'd0;
      out_valid_r <= 1'b0;
      final_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      final_r     <= final_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_final_word = final_r;

endmodule

>>> design/fnv64cd_checker.sv
// Port-level checker for the chained FNV-64 digest, with its bind to the top level.
// It depends only on the ports of fnv64_chained_digest.
`timescale 1ns / 1ps

module fnv64cd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_last_byte,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] out_digest_word,
  input logic        out_final_word
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_digest_word) &&
      $stable(out_final_word))
    else $error("output word changed while stalled");

  a_busy_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_last_byte |=> !in_ready)
    else $error("input accepted during the finish");

  a_first_word_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_final_word |-> !in_ready)
    else $error("input ready while the first digest word is pending");

  a_no_early_word: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_last_byte |=> !out_valid || out_final_word)
    else $error("first digest word shown right after the last byte");

endmodule

bind fnv64_chained_digest fnv64cd_checker u_fnv64cd_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .in_last_byte    (in_last_byte),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_digest_word (out_digest_word),
  .out_final_word  (out_final_word)
);

>>> bench/fnv64_digest_checker.sv
// Checker for the chained FNV-64 digest: predicts both digest words of every message
// and compares them, in order, with the words the block emits.
// It depends on nothing but the channel signals it watches.
`timescale 1ns / 1ps

module fnv64_digest_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_byte,
  input  logic        in_last_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [63:0] out_digest_word,
  input  logic        out_final_word,
  output int          mismatch_count,
  output int          pending_words,
  output int          words_checked
);

  localparam logic [63:0] OFFSET_BASIS    = 64'hCBF2_9CE4_8422_2325;
  localparam logic [63:0] HASH_MULTIPLIER = 64'h0000_0100_0000_01B3;

  typedef struct {
    logic [63:0] digest;
    logic        final_flag;
  } digest_word_t;

  digest_word_t expected_words_q[$];
  digest_word_t oldest_word;
  logic [63:0]  message_hash = OFFSET_BASIS;
  logic [63:0]  first_half;
  logic [63:0]  second_half;

  function automatic logic [63:0] byte_reverse(input logic [63:0] v);
    logic [63:0] r;
    for (int i = 0; i < 8; i++) begin
      r[8*i +: 8] = v[8*(7-i) +: 8];
    end
    return r;
  endfunction

  function automatic logic [63:0] fnv1a_of_word(input logic [63:0] v);
    logic [63:0] h;
    h = OFFSET_BASIS;
    for (int i = 7; i >= 0; i--) begin
      h = (h ^ {56'd0, v[8*i +: 8]}) * HASH_MULTIPLIER;
    end
    return h;
  endfunction

  function automatic logic [63:0] fnv1_of_word(input logic [63:0] v);
    logic [63:0] h;
    h = OFFSET_BASIS;
    for (int i = 7; i >= 0; i--) begin
      h = (h * HASH_MULTIPLIER) ^ {56'd0, v[8*i +: 8]};
    end
    return h;
  endfunction

  function automatic logic [63:0] extend_hash(input logic [63:0] h);
    return fnv1a_of_word(h ^ byte_reverse(fnv1a_of_word(h)));
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      message_hash = OFFSET_BASIS;
      expected_words_q.delete();
      mismatch_count = 0;
      words_checked = 0;
    end else begin
      if (in_valid && in_ready) begin
        message_hash = (message_hash * HASH_MULTIPLIER) ^ {56'd0, in_byte};
        if (in_last_byte) begin
          first_half = extend_hash(message_hash);
          second_half = extend_hash(fnv1_of_word(first_half));
          expected_words_q.push_back('{digest: first_half, final_flag: 1'b0});
          expected_words_q.push_back('{digest: second_half, final_flag: 1'b1});
          message_hash = OFFSET_BASIS;
        end
      end
      if (out_valid && out_ready) begin
        if (expected_words_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("Unexpected digest word %h final %b with nothing pending",
                     out_digest_word, out_final_word);
          end
        end else begin
          oldest_word = expected_words_q.pop_front();
          if (out_digest_word !== oldest_word.digest ||
              out_final_word !== oldest_word.final_flag) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("Digest word %0d: expected %h final %b, got %h final %b",
                       words_checked, oldest_word.digest, oldest_word.final_flag,
                       out_digest_word, out_final_word);
            end
          end
          words_checked++;
        end
      end
    end
    pending_words = expected_words_q.size();
  end

endmodule

>>> bench/tb_fnv64_chained_digest.sv
// Testbench top for the chained FNV-64 digest: drives message bytes and output stalls,
// and gives the verdict from the mismatch and pending-word counts of fnv64_digest_checker.
// It depends on the block's RTL and the checker module.
`timescale 1ns / 1ps

module tb_fnv64_chained_digest;

  localparam int CYCLE_LIMIT   = 1000000;
  localparam int DRAIN_LIMIT   = 20000;
  localparam int SETTLE_CYCLES = 60;
  localparam int HOLD_CYCLES   = 500;
  localparam int PHASE_ITEMS   = 670;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_byte = 8'd0;
  logic        in_last_byte = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [63:0] out_digest_word;
  logic        out_final_word;

  int mismatch_count;
  int pending_words;
  int words_checked;
  int send_idle_pct = 17;
  int recv_idle_pct = 78;
  int bytes_sent = 0;
  int messages_sent = 0;
  int cycle_count = 0;
  int drain_cycles = 0;
  logic hold_request = 1'b0;
  logic hold_rx = 1'b0;

  fnv64_chained_digest i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_byte         (in_byte),
    .in_last_byte    (in_last_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_digest_word (out_digest_word),
    .out_final_word  (out_final_word)
  );

  fnv64_digest_checker i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_byte         (in_byte),
    .in_last_byte    (in_last_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_digest_word (out_digest_word),
    .out_final_word  (out_final_word),
    .mismatch_count  (mismatch_count),
    .pending_words   (pending_words),
    .words_checked   (words_checked)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Called and returning just after a falling edge.
  task automatic send_word(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_byte <= b;
    in_last_byte <= last;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
    if (last) begin
      messages_sent++;
    end
    @(negedge clk);
  endtask

  task automatic send_random_message();
    int len;
    int pick;
    pick = $urandom_range(99);
    if (pick < 70) begin
      len = $urandom_range(8, 1);
    end else if (pick < 95) begin
      len = $urandom_range(32, 9);
    end else begin
      len = $urandom_range(120, 33);
    end
    for (int k = 0; k < len; k++) begin
      send_word(8'($urandom_range(255)), k == len - 1);
    end
  endtask

  initial begin
    forever begin
      @(negedge clk);
      out_ready <= !hold_rx && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    wait (hold_request);
    @(posedge clk);
    hold_rx = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_rx = 1'b0;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Run stopped after %0d cycles with %0d digest words outstanding",
             cycle_count, pending_words);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_word(8'h00, 1'b1);
    send_word(8'hFF, 1'b1);
    send_word(8'h00, 1'b0);
    send_word(8'hFF, 1'b0);
    send_word(8'h80, 1'b0);
    send_word(8'h01, 1'b1);
    send_word(8'h55, 1'b0);
    send_word(8'hAA, 1'b0);
    send_word(8'h0F, 1'b0);
    send_word(8'hF0, 1'b1);
    for (int k = 0; k < 8; k++) begin
      send_word(8'h00, k == 7);
    end

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 17;
          recv_idle_pct = 78;
        end
        1: begin
          send_idle_pct = 78;
          recv_idle_pct = 17;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
          hold_request = 1'b1;
        end
      endcase
      drain_cycles = bytes_sent + PHASE_ITEMS;
      while (bytes_sent < drain_cycles) begin
        send_random_message();
      end
    end
    in_valid <= 1'b0;

    drain_cycles = 0;
    while (pending_words != 0 && drain_cycles < DRAIN_LIMIT) begin
      @(posedge clk);
      drain_cycles++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d bytes in %0d messages and checked %0d digest words,",
             bytes_sent, messages_sent, words_checked);
    $display("under both idling mixes, a no-idle stretch and a long output stall.");
    if (pending_words != 0) begin
      $display("%0d expected digest words never arrived", pending_words);
    end
    if (mismatch_count == 0 && pending_words == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
design/fnv64cd_pkg.sv
design/fnv64cd_datapath.sv
design/fnv64cd_ctrl.sv
design/fnv64_chained_digest.sv
design/fnv64cd_checker.sv
bench/fnv64_digest_checker.sv
bench/tb_fnv64_chained_digest.sv
